// ===== rtl/core/iorb_pkg.sv =====
// Shared types and constants for the in-order response reorder buffer.
package iorb_pkg;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FILL  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_FLUSH = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BAD_ID = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_EXEC   = 2'd1,
    S_RETIRE = 2'd2,
    S_OUT    = 2'd3
  } state_t;

  // Most entries one flush may retire.
  localparam logic [4:0] MAX_CREDIT = 5'd16;

  typedef struct packed {
    logic load_req;
    logic do_alloc;
    logic do_fill;
    logic do_query;
    logic do_flush_none;
    logic do_retire;
  } cmd_t;

  typedef struct packed {
    req_type_t req_type;
    logic      flush_start;
    logic      more;
  } sts_t;

endpackage

// ===== rtl/core/iorb_ctrl.sv =====
// Controller state machine sequencing requests and flush retirement.
module iorb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  iorb_pkg::sts_t    sts,
  output iorb_pkg::cmd_t    cmd
);

  iorb_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iorb_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      iorb_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = iorb_pkg::S_EXEC;
        end
      end
      iorb_pkg::S_EXEC: begin
        state_nxt = iorb_pkg::S_OUT;
        case (sts.req_type)
          iorb_pkg::REQ_ALLOC: cmd.do_alloc = 1'b1;
          iorb_pkg::REQ_FILL:  cmd.do_fill  = 1'b1;
          iorb_pkg::REQ_QUERY: cmd.do_query = 1'b1;
          iorb_pkg::REQ_FLUSH: begin
            if (sts.flush_start) begin
              state_nxt = iorb_pkg::S_RETIRE;
            end else begin
              cmd.do_flush_none = 1'b1;
            end
          end
          default: cmd.do_flush_none = 1'b1;
        endcase
      end
      iorb_pkg::S_RETIRE: begin
        cmd.do_retire = 1'b1;
        state_nxt     = iorb_pkg::S_OUT;
      end
      iorb_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          // The next head entry was already known retireable when this
          // transaction was formed.
          state_nxt = sts.more ? iorb_pkg::S_RETIRE : iorb_pkg::S_IDLE;
        end
      end
      default: state_nxt = iorb_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/iorb_dpath.sv =====
// Datapath: ring pointers, ready flags, tag memory and result register.
module iorb_dpath #(
  parameter int DEPTH    = 16,
  parameter int TAG_BITS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [1:0]     in_req_type,
  input  logic [31:0]    in_slot_id,
  input  logic [31:0]    in_payload_tag,
  input  logic [4:0]     in_sink_credit,
  output logic [1:0]     out_status,
  output logic [31:0]    out_assigned_id,
  output logic [31:0]    out_retired_tag,
  output logic           out_retired_valid,
  output logic           out_is_ready,
  output logic [4:0]     out_pending_count,
  output logic           out_last,
  input  iorb_pkg::cmd_t cmd,
  output iorb_pkg::sts_t sts
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SW    = (TAG_BITS < 32) ? TAG_BITS : 32;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
  localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  // Latched request.
  iorb_pkg::req_type_t req_type_r;
  logic [31:0]         slot_id_r;
  logic [SW-1:0]       tag_r;
  logic [4:0]          credit_r;

  // Ring state.
  logic [IDX_W-1:0] head_r;
  logic [CNT_W-1:0] held_r;
  logic [31:0]      head_id_r;
  logic [31:0]      next_id_r;
  logic [DEPTH-1:0] ready_r;
  logic [4:0]       nret_r;
  logic             more_r;

  // Tag memory with registered read at the head.
  logic [SW-1:0] tag_mem [DEPTH];
  logic [SW-1:0] rd_data_r;

  // Result register.
  iorb_pkg::status_t status_r;
  logic [31:0]       assigned_id_r;
  logic [31:0]       retired_tag_r;
  logic              retired_valid_r;
  logic              query_rdy_r;
  logic [4:0]        pending_r;
  logic              last_r;

  logic [31:0]      id_gap;
  logic             in_win;
  logic [IDX_W:0]   pos_sum;
  logic [IDX_W-1:0] pos;
  logic [IDX_W:0]   tail_sum;
  logic [IDX_W-1:0] tail;
  logic [IDX_W-1:0] head_next;
  logic [4:0]       credit_c;
  logic [4:0]       nret_inc;
  logic             retire_last;
  logic             full;
  iorb_pkg::status_t fill_st;
  iorb_pkg::status_t query_st;

  always_comb begin
    id_gap   = slot_id_r - head_id_r;
    in_win   = (held_r != '0) && (id_gap < 32'(held_r));
    pos_sum  = (IDX_W + 1)'(head_r) + (IDX_W + 1)'(id_gap[CNT_W-1:0]);
    pos      = (pos_sum >= DEPTH_EXT) ? IDX_W'(pos_sum - DEPTH_EXT) : pos_sum[IDX_W-1:0];
    tail_sum = (IDX_W + 1)'(head_r) + (IDX_W + 1)'(held_r);
    tail     = (tail_sum >= DEPTH_EXT) ? IDX_W'(tail_sum - DEPTH_EXT)
                                       : tail_sum[IDX_W-1:0];
    head_next = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
    credit_c  = (credit_r > iorb_pkg::MAX_CREDIT) ? iorb_pkg::MAX_CREDIT : credit_r;
    nret_inc  = nret_r + 5'd1;
    full      = (held_r >= DEPTH_CNT);

    if (slot_id_r == 32'd0) begin
      fill_st = iorb_pkg::ST_BAD_ID;
    end else if (held_r == '0) begin
      fill_st = iorb_pkg::ST_EMPTY;
    end else if (!in_win) begin
      fill_st = iorb_pkg::ST_BAD_ID;
    end else begin
      fill_st = iorb_pkg::ST_OK;
    end

    if (held_r == '0) begin
      query_st = iorb_pkg::ST_EMPTY;
    end else if (!in_win) begin
      query_st = iorb_pkg::ST_BAD_ID;
    end else begin
      query_st = iorb_pkg::ST_OK;
    end

    // This retirement ends the flush when credit runs out, the ring empties,
    // or the following entry has not been filled yet.
    retire_last = (nret_inc >= credit_c) || (held_r == CNT_W'(1)) ||
                  !ready_r[head_next];

    sts.req_type    = req_type_r;
    sts.flush_start = (credit_c != 5'd0) && (held_r != '0) && ready_r[head_r];
    sts.more        = more_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      held_r    <= '0;
      head_id_r <= 32'd1;
      next_id_r <= 32'd1;
      ready_r   <= '0;
      nret_r    <= 5'd0;
      more_r    <= 1'b0;
    end else begin
      if (cmd.load_req) begin
        nret_r <= 5'd0;
        more_r <= 1'b0;
      end
      if (cmd.do_alloc && !full) begin
        ready_r[tail] <= 1'b0;
        next_id_r     <= next_id_r + 32'd1;
        held_r        <= held_r + 1'b1;
      end
      if (cmd.do_fill && (fill_st == iorb_pkg::ST_OK)) begin
        ready_r[pos] <= 1'b1;
      end
      if (cmd.do_retire) begin
        ready_r[head_r] <= 1'b0;
        head_r          <= head_next;
        head_id_r       <= head_id_r + 32'd1;
        held_r          <= held_r - 1'b1;
        nret_r          <= nret_inc;
        more_r          <= !retire_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_fill && (fill_st == iorb_pkg::ST_OK)) begin
      tag_mem[pos] <= tag_r;
    end
    rd_data_r <= tag_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_type_r <= iorb_pkg::req_type_t'(in_req_type);
      slot_id_r  <= in_slot_id;
      tag_r      <= in_payload_tag[SW-1:0];
      credit_r   <= in_sink_credit;
    end
    if (cmd.do_alloc) begin
      status_r        <= full ? iorb_pkg::ST_FULL : iorb_pkg::ST_OK;
      assigned_id_r   <= full ? 32'd0 : next_id_r;
      retired_tag_r   <= 32'd0;
      retired_valid_r <= 1'b0;
      query_rdy_r     <= 1'b0;
      pending_r       <= full ? 5'(held_r) : 5'(held_r + 1'b1);
      last_r          <= 1'b1;
    end
    if (cmd.do_fill) begin
      status_r        <= fill_st;
      assigned_id_r   <= 32'd0;
      retired_tag_r   <= 32'd0;
      retired_valid_r <= 1'b0;
      query_rdy_r     <= 1'b0;
      pending_r       <= 5'(held_r);
      last_r          <= 1'b1;
    end
    if (cmd.do_query) begin
      status_r        <= query_st;
      assigned_id_r   <= 32'd0;
      retired_tag_r   <= 32'd0;
      retired_valid_r <= 1'b0;
      query_rdy_r     <= (query_st == iorb_pkg::ST_OK) && ready_r[pos];
      pending_r       <= 5'(held_r);
      last_r          <= 1'b1;
    end
    if (cmd.do_flush_none) begin
      status_r        <= (held_r == '0) ? iorb_pkg::ST_EMPTY : iorb_pkg::ST_OK;
      assigned_id_r   <= 32'd0;
      retired_tag_r   <= 32'd0;
      retired_valid_r <= 1'b0;
      query_rdy_r     <= 1'b0;
      pending_r       <= 5'(held_r);
      last_r          <= 1'b1;
    end
    if (cmd.do_retire) begin
      status_r        <= iorb_pkg::ST_OK;
      assigned_id_r   <= head_id_r;
      retired_tag_r   <= 32'(rd_data_r);
      retired_valid_r <= 1'b1;
      query_rdy_r     <= 1'b0;
      pending_r       <= 5'(held_r - 1'b1);
      last_r          <= retire_last;
    end
  end

  assign out_status        = status_r;
  assign out_assigned_id   = assigned_id_r;
  assign out_retired_tag   = retired_tag_r;
  assign out_retired_valid = retired_valid_r;
  assign out_is_ready      = query_rdy_r;
  assign out_pending_count = pending_r;
  assign out_last          = last_r;

endmodule

// ===== rtl/core/in_order_response_reorder_buffer_top.sv =====
// Top level of the in-order response reorder buffer.
// The block handles one request at a time. An allocate, fill or query
// request is taken in S_IDLE, executed in S_EXEC, and its single result
// transaction is presented in S_OUT; with out_ready high the block returns
// to S_IDLE and is ready again. A flush that retires entries presents one
// result per retired entry, each built in S_RETIRE (the head entry's tag
// comes from the registered read of the tag memory) and handed over in
// S_OUT; one entry is handed over before another is retired, since the
// tag memory has a single read port and the result register is shared. The ring
// holds DEPTH entries; ready flags reset to zero and need no clearing pass.
module in_order_response_reorder_buffer_top #(
  parameter int DEPTH    = 16,
  parameter int TAG_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_slot_id,
  input  logic [31:0] in_payload_tag,
  input  logic [4:0]  in_sink_credit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_assigned_id,
  output logic [31:0] out_retired_tag,
  output logic        out_retired_valid,
  output logic        out_is_ready,
  output logic [4:0]  out_pending_count,
  output logic        out_last
);

  iorb_pkg::cmd_t cmd;
  iorb_pkg::sts_t sts;

  iorb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  iorb_dpath #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_req_type       (in_req_type),
    .in_slot_id        (in_slot_id),
    .in_payload_tag    (in_payload_tag),
    .in_sink_credit    (in_sink_credit),
    .out_status        (out_status),
    .out_assigned_id   (out_assigned_id),
    .out_retired_tag   (out_retired_tag),
    .out_retired_valid (out_retired_valid),
    .out_is_ready      (out_is_ready),
    .out_pending_count (out_pending_count),
    .out_last          (out_last),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule
